// File: rtl/csfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte-wide CRC functions for the serial frame parser.
// Used by csfp_parser and crc_checked_serial_frame_parser_unit.
package csfp_pkg;

   localparam int MAX_FRAME   = 512;
   localparam int POS_W       = $clog2(MAX_FRAME);
   localparam int LEN_W       = 16;
   localparam int SUM_W       = LEN_W + 1;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int MAXLEN_W    = 10;

   localparam logic [CSR_IDX_W-1:0]  CSR_START_BYTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_MAX_FRAME  = 1'd1;

   localparam logic [7:0]          START_BYTE_RST = 8'd165;
   localparam logic [MAXLEN_W-1:0] MAX_FRAME_RST  = 10'd512;
   localparam logic [7:0]          CRC8_INIT      = 8'hFF;
   localparam logic [15:0]         CRC16_INIT     = 16'hFFFF;
   localparam logic [7:0]          CRC8_POLY      = 8'h8C;
   localparam logic [15:0]         CRC16_POLY     = 16'h8408;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STAT_GOOD     = 2'd0,
      STAT_CRC16    = 2'd1,
      STAT_CRC8     = 2'd2,
      STAT_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      logic [8:0]  payload_index;
      logic [15:0] command_id;
      logic [15:0] payload_length;
      status_type  frame_status;
      logic        last_of_frame;
   } result_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/csfp_parser.sv
`timescale 1ns / 1ps
// Frame parse state, header and frame CRCs, and control registers.
// Depends on csfp_pkg; produces at most one result per accepted byte.
module csfp_parser
   import csfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_take,
   input  logic [7:0]            byte_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output logic                  res_valid,
   output result_type            res_data
);

   logic [7:0]          start_ff;
   logic [MAXLEN_W-1:0] max_len_ff;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] hdr_len_ff, hdr_len_in;
   logic [15:0]      cmd_ff, cmd_in;
   logic [7:0]       crc8_ff, crc8_in;
   logic [15:0]      crc16_ff, crc16_in;
   logic [7:0]       rcv_lo_ff, rcv_lo_in;

   logic [7:0]       crc8_next;
   logic [15:0]      crc16_next;
   logic [SUM_W-1:0] total_len;
   logic [SUM_W-1:0] body_end;
   logic [SUM_W-1:0] pos_ext;
   logic [SUM_W-1:0] idx_wide;
   logic             too_long;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_BYTE_RST;
         max_len_ff <= MAX_FRAME_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_BYTE: start_ff   <= csr_wr_data[7:0];
            CSR_MAX_FRAME:  max_len_ff <= csr_wr_data[MAXLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         pos_ff     <= '0;
         hdr_len_ff <= '0;
         cmd_ff     <= '0;
         crc8_ff    <= CRC8_INIT;
         crc16_ff   <= CRC16_INIT;
         rcv_lo_ff  <= '0;
      end else if (byte_take) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         hdr_len_ff <= hdr_len_in;
         cmd_ff     <= cmd_in;
         crc8_ff    <= crc8_in;
         crc16_ff   <= crc16_in;
         rcv_lo_ff  <= rcv_lo_in;
      end
   end

   always_comb begin
      crc8_next  = crc8_step(crc8_ff, byte_data);
      crc16_next = crc16_step(crc16_ff, byte_data);
      total_len  = SUM_W'(hdr_len_ff) + SUM_W'(9);
      body_end   = SUM_W'(hdr_len_ff) + SUM_W'(7);
      pos_ext    = SUM_W'(pos_ff);
      idx_wide   = pos_ext - SUM_W'(7);
      too_long   = (total_len > SUM_W'(max_len_ff)) || (total_len > SUM_W'(MAX_FRAME));

      phase_in   = phase_ff;
      pos_in     = pos_ff;
      hdr_len_in = hdr_len_ff;
      cmd_in     = cmd_ff;
      crc8_in    = crc8_ff;
      crc16_in   = crc16_ff;
      rcv_lo_in  = rcv_lo_ff;

      res_valid  = 1'b0;
      res_data   = '{result_kind:    KIND_VERDICT,
                     payload_byte:   8'd0,
                     payload_index:  9'd0,
                     command_id:     16'd0,
                     payload_length: 16'd0,
                     frame_status:   STAT_GOOD,
                     last_of_frame:  1'b1};

      unique case (phase_ff)
         PH_HUNT: begin
            if (byte_data == start_ff) begin
               crc8_in    = crc8_step(CRC8_INIT, byte_data);
               crc16_in   = crc16_step(CRC16_INIT, byte_data);
               hdr_len_in = '0;
               cmd_in     = '0;
               rcv_lo_in  = '0;
               pos_in     = POS_W'(1);
               phase_in   = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (pos_ff == POS_W'(1)) begin
               hdr_len_in = {8'd0, byte_data};
            end else if (pos_ff == POS_W'(2)) begin
               hdr_len_in = {byte_data, hdr_len_ff[7:0]};
            end
            if (pos_ff < POS_W'(4)) begin
               crc8_in  = crc8_next;
               crc16_in = crc16_next;
               pos_in   = pos_ff + POS_W'(1);
            end else if (byte_data != crc8_ff) begin
               phase_in  = PH_HUNT;
               pos_in    = '0;
               res_valid = 1'b1;
               res_data.frame_status = STAT_CRC8;
            end else if (too_long) begin
               crc16_in  = crc16_next;
               phase_in  = PH_HUNT;
               pos_in    = '0;
               res_valid = 1'b1;
               res_data.payload_length = hdr_len_ff;
               res_data.frame_status   = STAT_TOO_LONG;
            end else begin
               crc16_in = crc16_next;
               pos_in   = POS_W'(5);
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (pos_ext < body_end) begin
               crc16_in = crc16_next;
               pos_in   = pos_ff + POS_W'(1);
               if (pos_ff == POS_W'(5)) begin
                  cmd_in = {8'd0, byte_data};
               end else if (pos_ff == POS_W'(6)) begin
                  cmd_in = {byte_data, cmd_ff[7:0]};
               end else begin
                  res_valid = 1'b1;
                  res_data.result_kind    = KIND_PAYLOAD;
                  res_data.payload_byte   = byte_data;
                  res_data.payload_index  = idx_wide[8:0];
                  res_data.command_id     = cmd_ff;
                  res_data.payload_length = hdr_len_ff;
                  res_data.last_of_frame  = 1'b0;
               end
            end else if (pos_ext == body_end) begin
               rcv_lo_in = byte_data;
               pos_in    = pos_ff + POS_W'(1);
            end else begin
               phase_in  = PH_HUNT;
               pos_in    = '0;
               res_valid = 1'b1;
               res_data.command_id     = cmd_ff;
               res_data.payload_length = hdr_len_ff;
               res_data.frame_status   = ({byte_data, rcv_lo_ff} == crc16_ff) ?
                                         STAT_GOOD : STAT_CRC16;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            pos_in   = '0;
         end
      endcase
   end

endmodule

// File: rtl/crc_checked_serial_frame_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the CRC-checked serial frame parser: ports and result register.
// Depends on csfp_pkg and csfp_parser.
//
// Takes one received byte per clock and gives at most one result per byte,
// registered in a single result register: each payload byte as it arrives,
// and one verdict word closing every frame whose header got through the start
// byte hunt (good, CRC16 bad, header CRC8 bad, or frame too long). A byte is
// taken in the same cycle the pending result is taken, so the input only stalls
// while the result register is full and rsp_stall is high. There is no start-up
// delay after reset. Write csr_ registers only while no frame is in flight.
module crc_checked_serial_frame_parser_unit
   import csfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic [7:0]            rsp_payload_byte,
   output logic [8:0]            rsp_payload_index,
   output logic [15:0]           rsp_command_id,
   output logic [15:0]           rsp_payload_length,
   output logic [1:0]            rsp_frame_status,
   output logic                  rsp_last_of_frame,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic       take;
   logic       res_valid;
   result_type res_data;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   csfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (take),
      .byte_data   (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_data_ff.result_kind;
   assign rsp_payload_byte   = rsp_data_ff.payload_byte;
   assign rsp_payload_index  = rsp_data_ff.payload_index;
   assign rsp_command_id     = rsp_data_ff.command_id;
   assign rsp_payload_length = rsp_data_ff.payload_length;
   assign rsp_frame_status   = rsp_data_ff.frame_status;
   assign rsp_last_of_frame  = rsp_data_ff.last_of_frame;

endmodule
